/* hw/rtl/gf2m_arithmetic_unit_core_defines.svh */
// ----------------------------------------------------------------------------
// gf2m_arithmetic_unit_core_defines.svh
// Assertion macros used by the checker file of the GF(2^m) unit.
// ----------------------------------------------------------------------------
`ifndef GF2M_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define GF2M_ARITHMETIC_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, reset masked.
`define GFAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset masked.
`define GFAU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/gfau_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfau_pkg
// Types and fixed constants of the GF(2^m) arithmetic unit.
// ----------------------------------------------------------------------------
package gfau_pkg;

	localparam int FIELD_W   = 64;
	localparam int DEG_W     = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic [FIELD_W-1:0] POLY_RESET   = 64'd27;
	localparam logic [DEG_W-1:0]   DEGREE_RESET = 7'd64;

	localparam logic [CFG_IDX_W-1:0] REG_POLY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 2'd1;

	typedef enum logic [1:0] {
		CMD_MUL = 2'd0,
		CMD_POW = 2'd1,
		CMD_INV = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

endpackage

/* hw/rtl/gfau_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfau_mul
// Bit-serial GF(2^m) multiplier: one multiplier bit per cycle, reduce per shift.
// ----------------------------------------------------------------------------
module gfau_mul #(
	parameter int W  = 64,
	parameter int MW = $clog2(W + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  op_a,
	input  logic [W-1:0]  op_b,
	input  logic [W-1:0]  poly,
	input  logic [W-1:0]  mask,
	input  logic [W-1:0]  top,
	input  logic [MW-1:0] last_idx,
	output logic          done,
	output logic [W-1:0]  product
);

	logic          running_q;
	logic          done_q;
	logic [MW-1:0] cnt_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  t_q;
	logic [W-1:0]  b_q;
	logic          hi;
	logic [W-1:0]  t_next;

	assign hi     = |(t_q & top);
	assign t_next = ({t_q[W-2:0], 1'b0} & mask) ^ (hi ? poly : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				cnt_q     <= '0;
			end else if (running_q) begin
				cnt_q <= cnt_q + MW'(1);
				if (cnt_q == last_idx) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			t_q   <= op_a;
			b_q   <= op_b;
		end else if (running_q) begin
			acc_q <= acc_q ^ (b_q[0] ? t_q : '0);
			t_q   <= t_next;
			b_q   <= {1'b0, b_q[W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

/* hw/rtl/gf2m_arithmetic_unit_core.sv */
`timescale 1ns / 1ps
// Each field multiply runs on the single bit-serial multiplier. Multiply
// needs 1 such multiply; power up to 2*bitlen(exponent)-1; reciprocal 2m-2
// (m >= 2) and divide one more.
// One item at a time: start is taken while busy is low, result_valid pulses once.
// Reset returns the sequencer to idle, reduction_poly to 27 and field_degree to 64.
// ----------------------------------------------------------------------------
// gf2m_arithmetic_unit_core
// GF(2^m) multiply, power, reciprocal and divide over a bit-serial multiplier.
// ----------------------------------------------------------------------------
module gf2m_arithmetic_unit_core
	import gfau_pkg::*;
#(
	parameter int MAX_DEGREE = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           command,
	input  logic [FIELD_W-1:0]   operand_a,
	input  logic [FIELD_W-1:0]   operand_b,
	output logic [FIELD_W-1:0]   result,
	output logic                 result_valid,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FIELD_W-1:0]   cfg_data
);

	localparam int W  = MAX_DEGREE;
	localparam int MW = $clog2(W + 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_STEP  = 5'b00010,
		ST_MACC  = 5'b00100,
		ST_MSQR  = 5'b01000,
		ST_FINAL = 5'b10000
	} state_t;

	state_t               state_q;
	logic [FIELD_W-1:0]   poly_cfg_q;
	logic [DEG_W-1:0]     deg_q;
	cmd_t                 cmd_q;
	logic [W-1:0]         a_q;
	logic [W-1:0]         acc_q;
	logic [W-1:0]         base_q;
	logic [FIELD_W-1:0]   e_q;
	logic [W-1:0]         mask_q;
	logic [W-1:0]         top_q;
	logic [W-1:0]         poly_q;
	logic [MW-1:0]        last_q;
	logic [FIELD_W-1:0]   result_q;
	logic                 result_valid_q;

	logic [MW-1:0]        m_eff;
	logic [W-1:0]         mask_c;
	logic [W-1:0]         top_c;
	logic [W-1:0]         a_in;
	logic [W-1:0]         b_el;
	logic [FIELD_W-1:0]   inv_e;
	logic                 accept;
	logic                 e_nz;
	logic                 mul_start;
	logic [W-1:0]         mul_a;
	logic [W-1:0]         mul_b;
	logic                 mul_done;
	logic [W-1:0]         mul_prod;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// Clamp the degree into 1..MAX_DEGREE.
	always_comb begin
		if (deg_q == '0)
			m_eff = MW'(1);
		else if (deg_q > DEG_W'(MAX_DEGREE))
			m_eff = MW'(MAX_DEGREE);
		else
			m_eff = MW'(deg_q);
		for (int i = 0; i < W; i++) begin
			mask_c[i] = (MW'(i) < m_eff);
			top_c[i]  = (MW'(i) == (m_eff - MW'(1)));
		end
	end

	assign a_in  = operand_a[W-1:0] & mask_c;
	assign b_el  = operand_b[W-1:0] & mask_c;
	// 2^m - 2: every element bit set but bit 0
	assign inv_e = FIELD_W'(mask_c & ~W'(1));

	assign e_nz      = |e_q;
	assign mul_start = (state_q == ST_STEP) &&
		(e_nz || (cmd_q == CMD_MUL) || (cmd_q == CMD_DIV));
	assign mul_a     = !e_nz ? a_q : (e_q[0] ? acc_q : base_q);
	assign mul_b     = !e_nz ? acc_q : base_q;

	gfau_mul #(
		.W  (W),
		.MW (MW)
	) u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mul_start),
		.op_a     (mul_a),
		.op_b     (mul_b),
		.poly     (poly_q),
		.mask     (mask_q),
		.top      (top_q),
		.last_idx (last_q),
		.done     (mul_done),
		.product  (mul_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_cfg_q <= POLY_RESET;
			deg_q      <= DEGREE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_POLY:   poly_cfg_q <= cfg_data;
				REG_DEGREE: deg_q      <= cfg_data[DEG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (e_nz)
						state_q <= e_q[0] ? ST_MACC : ST_MSQR;
					else if (mul_start)
						state_q <= ST_FINAL;
					else begin
						state_q        <= ST_IDLE;
						result_valid_q <= 1'b1;
					end
				end
				ST_MACC: begin
					if (mul_done) state_q <= ST_STEP;
				end
				ST_MSQR: begin
					if (mul_done) state_q <= ST_STEP;
				end
				ST_FINAL: begin
					if (mul_done) begin
						state_q        <= ST_IDLE;
						result_valid_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q  <= cmd_t'(command);
					a_q    <= a_in;
					mask_q <= mask_c;
					top_q  <= top_c;
					poly_q <= poly_cfg_q[W-1:0] & mask_c;
					last_q <= m_eff - MW'(1);
					case (cmd_t'(command))
						CMD_MUL: begin
							// run the final multiply straight away
							e_q    <= '0;
							acc_q  <= b_el;
							base_q <= a_in;
						end
						CMD_POW: begin
							e_q    <= operand_b;
							acc_q  <= W'(1);
							base_q <= a_in;
						end
						CMD_INV: begin
							e_q    <= inv_e;
							acc_q  <= W'(1);
							base_q <= a_in;
						end
						CMD_DIV: begin
							e_q    <= inv_e;
							acc_q  <= W'(1);
							base_q <= b_el;
						end
						default: begin
							e_q    <= '0;
							acc_q  <= W'(1);
							base_q <= a_in;
						end
					endcase
				end
			end
			ST_STEP: begin
				if (!e_nz && !mul_start) result_q <= FIELD_W'(acc_q);
			end
			ST_MACC: begin
				if (mul_done) begin
					acc_q  <= mul_prod;
					e_q[0] <= 1'b0;
				end
			end
			ST_MSQR: begin
				if (mul_done) begin
					base_q <= mul_prod;
					e_q    <= {1'b0, e_q[FIELD_W-1:1]};
				end
			end
			ST_FINAL: begin
				if (mul_done) result_q <= FIELD_W'(mul_prod);
			end
			default: ;
		endcase
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

/* hw/rtl/gfau_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfau_checker
// Port-level checks on the start/busy/result_valid sequencing of the unit.
// ----------------------------------------------------------------------------
`include "gf2m_arithmetic_unit_core_defines.svh"

module gfau_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic result_valid
);

	// an accepted beat always starts work
	`GFAU_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy, "accepted start did not raise busy")
	// one result per item, never two in a row
	`GFAU_ASSERT_NXT(a_single_pulse, clk, arst_n, result_valid, !result_valid, "result_valid held for two cycles")
	// a result only closes out work in flight
	`GFAU_ASSERT_IMP(a_valid_after_busy, clk, arst_n, result_valid, $past(busy) && !busy, "result_valid without prior work")
	// finishing work always delivers its result
	`GFAU_ASSERT_IMP(a_fall_delivers, clk, arst_n, $fell(busy), result_valid, "busy dropped without a result")

endmodule

bind gf2m_arithmetic_unit_core gfau_checker u_gfau_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid)
);
